FILE: rtl/mfa_pkg.sv
// shared types and constants for the mixed fraction alu
`timescale 1ns / 1ps
`default_nettype none
package mfa_pkg;
    localparam int OPERAND_BITS   = 12;
    localparam int WHOLE_OUT_BITS = 47;
    localparam int FRAC_OUT_BITS  = 35;
    localparam int MAG_BITS       = 2 * OPERAND_BITS + 1;
    localparam int WIDE_BITS      = 2 * MAG_BITS + 1;
    localparam int CNT_BITS       = $clog2(WIDE_BITS + 1);

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    typedef enum logic [2:0] {
        CMD_IDLE,
        CMD_LOAD,
        CMD_FORM,
        CMD_GCD_START,
        CMD_GCD_STEP,
        CMD_RED_START,
        CMD_DIV_STEP,
        CMD_FINISH
    } t_cmd;

    typedef struct packed {
        logic zero_den;
        logic div_done;
        logic gcd_done;
        logic red_phase_last;
    } t_status;
endpackage
`default_nettype wire

FILE: rtl/mixed_fraction_alu.sv
// top level of the mixed fraction alu
`timescale 1ns / 1ps
`default_nettype none
// Exact add, subtract, multiply or divide of two signed mixed numbers, one request at
// a time. The fraction is reduced by a gcd built from repeated shift-subtract
// remainders (one per Euclid step) and then three divisions (numerator by gcd,
// denominator by gcd, whole part), all on the single shared divider, so a request
// occupies the block longer the more Euclid steps its gcd takes, plus any output
// stall. o_stall is high while a request is in work.
module mixed_fraction_alu import mfa_pkg::*; (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [1:0]                     i_operation,
    input  wire logic signed [OPERAND_BITS-1:0] i_first_whole,
    input  wire logic [OPERAND_BITS-1:0]        i_first_num,
    input  wire logic [OPERAND_BITS-1:0]        i_first_den,
    input  wire logic signed [OPERAND_BITS-1:0] i_second_whole,
    input  wire logic [OPERAND_BITS-1:0]        i_second_num,
    input  wire logic [OPERAND_BITS-1:0]        i_second_den,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic signed [WHOLE_OUT_BITS-1:0]    o_result_whole,
    output logic [FRAC_OUT_BITS-1:0]            o_result_num,
    output logic [FRAC_OUT_BITS-1:0]            o_result_den,
    output logic                                o_zero_divide
);
    t_cmd    w_cmd;
    t_status w_status;

    mfa_control u_control (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall,
        .i_status(w_status), .o_cmd(w_cmd), .o_zero_divide
    );

    mfa_datapath u_datapath (
        .i_clk, .i_cmd(w_cmd), .i_operation,
        .i_first_whole, .i_first_num, .i_first_den,
        .i_second_whole, .i_second_num, .i_second_den,
        .o_status(w_status), .o_result_whole, .o_result_num, .o_result_den
    );
endmodule
`default_nettype wire

FILE: rtl/mfa_datapath.sv
// datapath: operand forming, gcd by repeated remainder, and reduction by shift-subtract division
`timescale 1ns / 1ps
`default_nettype none
module mfa_datapath import mfa_pkg::*; (
    input  wire logic                             i_clk,
    input  wire t_cmd                             i_cmd,
    input  wire logic [1:0]                       i_operation,
    input  wire logic signed [OPERAND_BITS-1:0]   i_first_whole,
    input  wire logic [OPERAND_BITS-1:0]          i_first_num,
    input  wire logic [OPERAND_BITS-1:0]          i_first_den,
    input  wire logic signed [OPERAND_BITS-1:0]   i_second_whole,
    input  wire logic [OPERAND_BITS-1:0]          i_second_num,
    input  wire logic [OPERAND_BITS-1:0]          i_second_den,
    output t_status                               o_status,
    output logic signed [WHOLE_OUT_BITS-1:0]      o_result_whole,
    output logic [FRAC_OUT_BITS-1:0]              o_result_num,
    output logic [FRAC_OUT_BITS-1:0]              o_result_den
);
    // operand registers
    logic [1:0]                r_op;
    logic                      r_s1, r_s2;
    logic [MAG_BITS-1:0]       r_m1, r_m2;
    logic [OPERAND_BITS-1:0]   r_d1, r_d2;
    // signed result fraction as sign + magnitude
    logic                      r_num_neg, r_den_neg;
    logic [WIDE_BITS-1:0]      r_anum, r_aden;
    // gcd registers
    logic [WIDE_BITS-1:0]      r_gx, r_gy;
    // divider registers
    logic [WIDE_BITS-1:0]      r_dvd, r_dvs, r_quo, r_rem;
    logic [CNT_BITS-1:0]       r_cnt;
    logic [1:0]                r_phase;   // 0 num/g, 1 den/g, 2 num/den, 3 gcd remainder
    logic                      r_busy;
    logic [WIDE_BITS-1:0]      r_rn, r_rd;
    logic                      r_zero;

    logic [WIDE_BITS-1:0] w_p1, w_p2;
    logic [WIDE_BITS:0]   w_sum;
    logic [WIDE_BITS:0]   w_trial;
    logic [WIDE_BITS-1:0] w_rem_sh;

    // magnitude of a mixed operand: |w|*den + num, one multiplier per operand
    function automatic logic [MAG_BITS-1:0] mix_mag(
        input logic signed [OPERAND_BITS-1:0] w,
        input logic [OPERAND_BITS-1:0] n,
        input logic [OPERAND_BITS-1:0] d
    );
        logic [OPERAND_BITS:0] aw;
        logic [2*OPERAND_BITS+1:0] prod;
        begin
            aw   = w[OPERAND_BITS-1] ? (OPERAND_BITS+1)'(-$signed({w[OPERAND_BITS-1], w}))
                                     : {1'b0, w};
            prod = (2*OPERAND_BITS+2)'(aw * d) + (2*OPERAND_BITS+2)'(n);
            return prod[MAG_BITS-1:0];
        end
    endfunction

    assign w_rem_sh = {r_rem[WIDE_BITS-2:0], r_dvd[WIDE_BITS-1]};
    assign w_trial  = {1'b0, w_rem_sh} - {1'b0, r_dvs};

    always_comb begin
        w_p1 = WIDE_BITS'(r_m1 * r_d2);
        w_p2 = WIDE_BITS'(r_m2 * r_d1);
        unique case ({r_s1, r_s2})
            2'b00, 2'b11: w_sum = {1'b0, w_p1} + {1'b0, w_p2};
            default:      w_sum = (w_p1 >= w_p2) ? {1'b0, w_p1} - {1'b0, w_p2}
                                                 : {1'b0, w_p2} - {1'b0, w_p1};
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            CMD_LOAD: begin
                r_op   <= i_operation;
                r_d1   <= i_first_den;
                r_d2   <= i_second_den;
                r_s1   <= i_first_whole[OPERAND_BITS-1];
                r_s2   <= i_second_whole[OPERAND_BITS-1] ^ (i_operation == OP_SUB);
                r_m1   <= mix_mag(i_first_whole, i_first_num, i_first_den);
                r_m2   <= mix_mag(i_second_whole, i_second_num, i_second_den);
                r_zero <= (i_first_den == '0) || (i_second_den == '0);
            end
            CMD_FORM: begin
                unique case (r_op)
                    OP_ADD, OP_SUB: begin
                        r_anum    <= w_sum[WIDE_BITS-1:0];
                        r_num_neg <= (r_s1 == r_s2) ? r_s1 : ((w_p1 >= w_p2) ? r_s1 : r_s2);
                        r_aden    <= WIDE_BITS'(r_d1 * r_d2);
                        r_den_neg <= 1'b0;
                    end
                    OP_MUL: begin
                        r_anum    <= WIDE_BITS'(r_m1 * r_m2);
                        r_num_neg <= r_s1 ^ r_s2;
                        r_aden    <= WIDE_BITS'(r_d1 * r_d2);
                        r_den_neg <= 1'b0;
                    end
                    default: begin
                        r_anum    <= w_p1;
                        r_num_neg <= r_s1;
                        r_aden    <= w_p2;
                        r_den_neg <= r_s2;
                        if (r_m2 == '0) r_zero <= 1'b1;
                    end
                endcase
            end
            CMD_GCD_START: begin
                r_gx    <= r_aden;
                r_gy    <= r_anum;
                // reduction starts from the gcd phase even when no euclid step runs
                r_phase <= 2'd3;
            end
            CMD_GCD_STEP: begin
                // launch remainder gx % gy
                r_dvd   <= r_gx;
                r_dvs   <= r_gy;
                r_rem   <= '0;
                r_cnt   <= CNT_BITS'(WIDE_BITS);
                r_phase <= 2'd3;
                r_busy  <= 1'b1;
            end
            CMD_RED_START: begin
                r_dvd   <= (r_phase == 2'd3) ? r_anum : ((r_phase == 2'd0) ? r_aden : r_rn);
                r_dvs   <= (r_phase == 2'd1) ? r_rd : r_gx;
                r_rem   <= '0;
                r_cnt   <= CNT_BITS'(WIDE_BITS);
                r_phase <= (r_phase == 2'd3) ? 2'd0 : r_phase + 2'd1;
                r_busy  <= 1'b1;
            end
            CMD_DIV_STEP: begin
                if (r_cnt != '0) begin
                    r_dvd <= {r_dvd[WIDE_BITS-2:0], 1'b0};
                    r_quo <= {r_quo[WIDE_BITS-2:0], ~w_trial[WIDE_BITS]};
                    r_rem <= w_trial[WIDE_BITS] ? w_rem_sh : w_trial[WIDE_BITS-1:0];
                    r_cnt <= r_cnt - 1'b1;
                end else if (r_busy) begin
                    r_busy <= 1'b0;
                    unique case (r_phase)
                        2'd3: begin
                            r_gx <= r_gy;
                            r_gy <= r_rem;
                        end
                        2'd0: r_rn <= r_quo;
                        2'd1: r_rd <= r_quo;
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    logic w_res_neg;
    assign w_res_neg = r_num_neg ^ r_den_neg;

    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_FINISH) begin
            if (r_zero) begin
                o_result_whole <= '0;
                o_result_num   <= '0;
                o_result_den   <= '0;
            end else begin
                // quotient sign follows numerator xor denominator; remainder magnitude
                o_result_whole <= w_res_neg ? WHOLE_OUT_BITS'(-$signed({1'b0, r_quo}))
                                            : WHOLE_OUT_BITS'(r_quo);
                o_result_num   <= FRAC_OUT_BITS'(r_rem);
                o_result_den   <= (r_rem == '0) ? FRAC_OUT_BITS'(1) : FRAC_OUT_BITS'(r_rd);
            end
        end
    end

    assign o_status.zero_den       = r_zero;
    assign o_status.div_done       = (r_cnt == '0) && !r_busy;
    assign o_status.gcd_done       = (r_gy == '0);
    assign o_status.red_phase_last = (r_phase == 2'd2);
endmodule
`default_nettype wire

FILE: rtl/mfa_control.sv
// controller state machine that sequences the datapath
`timescale 1ns / 1ps
`default_nettype none
module mfa_control import mfa_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_stall,
    output logic       o_valid,
    input  wire logic  i_stall,
    input  wire t_status i_status,
    output t_cmd       o_cmd,
    output logic       o_zero_divide
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FORM = 3'd1;
    localparam logic [2:0] S_GCDI = 3'd2;
    localparam logic [2:0] S_GCDL = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_RED  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_in_gcd, n_in_gcd;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_comb begin
        n_state  = r_state;
        n_in_gcd = r_in_gcd;
        o_cmd    = CMD_IDLE;
        unique case (r_state)
            S_IDLE: if (i_valid) begin
                o_cmd   = CMD_LOAD;
                n_state = S_FORM;
            end
            S_FORM: begin
                o_cmd   = CMD_FORM;
                n_state = S_GCDI;
            end
            S_GCDI: begin
                if (i_status.zero_den) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd   = CMD_GCD_START;
                    n_state = S_GCDL;
                end
            end
            S_GCDL: begin
                n_in_gcd = 1'b1;
                if (i_status.gcd_done) begin
                    o_cmd   = CMD_RED_START;
                    n_in_gcd = 1'b0;
                end else begin
                    o_cmd   = CMD_GCD_STEP;
                end
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd = CMD_DIV_STEP;
                if (i_status.div_done) n_state = r_in_gcd ? S_GCDL : S_RED;
            end
            S_RED: begin
                if (i_status.red_phase_last) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd   = CMD_RED_START;
                    n_state = S_DIV;
                end
            end
            S_FIN: begin
                o_cmd   = CMD_FINISH;
                n_state = S_OUT;
            end
            default: if (!i_stall) n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_in_gcd <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_in_gcd <= n_in_gcd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd == CMD_FINISH) o_zero_divide <= i_status.zero_den;
    end

    a_out_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> (r_state == S_OUT)) else $error("finish not followed by output");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid) else $error("result dropped while stalled");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (o_cmd != CMD_LOAD)) else $error("load while busy");
endmodule
`default_nettype wire

FILE: tb/sv/mixed_fraction_alu_tb.sv
// testbench for the mixed fraction alu: randomized requests checked against a predictor
`timescale 1ns / 1ps
module mixed_fraction_alu_tb;
    import mfa_pkg::*;

    localparam int  LIMIT_CYCLES = 10000000;
    localparam int  DRAIN_AT     = 150;
    localparam int  TAIL_CYCLES  = 4000;

    typedef struct {
        logic [1:0]                     op;
        logic signed [OPERAND_BITS-1:0] w1;
        logic [OPERAND_BITS-1:0]        n1;
        logic [OPERAND_BITS-1:0]        d1;
        logic signed [OPERAND_BITS-1:0] w2;
        logic [OPERAND_BITS-1:0]        n2;
        logic [OPERAND_BITS-1:0]        d2;
    } t_req;

    typedef struct {
        logic signed [WHOLE_OUT_BITS-1:0] whole;
        logic [FRAC_OUT_BITS-1:0]         num;
        logic [FRAC_OUT_BITS-1:0]         den;
        logic                             zdiv;
    } t_frac;

    logic i_clk, i_rst_n, i_valid, i_stall;
    logic o_stall, o_valid, o_zero_divide;
    logic [1:0] i_operation;
    logic signed [OPERAND_BITS-1:0] i_first_whole, i_second_whole;
    logic [OPERAND_BITS-1:0] i_first_num, i_first_den, i_second_num, i_second_den;
    logic signed [WHOLE_OUT_BITS-1:0] o_result_whole;
    logic [FRAC_OUT_BITS-1:0] o_result_num, o_result_den;

    t_req  pending_q[$];
    t_frac fraction_q[$];
    int    mismatches = 0;
    int    cycles = 0;
    int    sent = 0;
    int    send_gap = 0;
    int    stall_left = 0;
    logic  taken = 1'b0;

    mixed_fraction_alu dut (.*);

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 400);
    endfunction

    function automatic longint mixed_value(logic signed [OPERAND_BITS-1:0] w,
                                           logic [OPERAND_BITS-1:0] n,
                                           logic [OPERAND_BITS-1:0] d);
        longint wv, mag;
        wv  = w;
        mag = (wv < 0 ? -wv : wv) * longint'(d) + longint'(n);
        return wv < 0 ? -mag : mag;
    endfunction

    function automatic t_frac reduce_fraction(t_req r);
        t_frac  f;
        longint a, b, top, bot, q, rem;
        longint unsigned x, y, t;
        f = '{whole: '0, num: '0, den: '0, zdiv: 1'b0};
        if (r.d1 == 0 || r.d2 == 0) begin
            f.zdiv = 1'b1;
            return f;
        end
        a = mixed_value(r.w1, r.n1, r.d1);
        b = mixed_value(r.w2, r.n2, r.d2);
        case (r.op)
            OP_ADD, OP_SUB: begin
                if (r.op == OP_SUB) b = -b;
                top = a * longint'(r.d2) + b * longint'(r.d1);
                bot = longint'(r.d1) * longint'(r.d2);
            end
            OP_MUL: begin
                top = a * b;
                bot = longint'(r.d1) * longint'(r.d2);
            end
            default: begin
                if (b == 0) begin
                    f.zdiv = 1'b1;
                    return f;
                end
                top = a * longint'(r.d2);
                bot = b * longint'(r.d1);
            end
        endcase
        x = bot < 0 ? -bot : bot;
        y = top < 0 ? -top : top;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        top = top / longint'(x);
        bot = bot / longint'(x);
        q   = top / bot;
        rem = top % bot;
        f.whole = q[WHOLE_OUT_BITS-1:0];
        f.num   = FRAC_OUT_BITS'(rem < 0 ? -rem : rem);
        f.den   = (rem == 0) ? FRAC_OUT_BITS'(1) : FRAC_OUT_BITS'(bot < 0 ? -bot : bot);
        return f;
    endfunction

    function automatic logic [OPERAND_BITS-1:0] rand_field(bit allow_zero);
        int r;
        r = $urandom_range(0, 99);
        if (allow_zero && r < 4) return '0;
        if (r < 40) return OPERAND_BITS'($urandom_range(1, 15));
        if (r < 50) return {OPERAND_BITS{1'b1}};
        return OPERAND_BITS'($urandom);
    endfunction

    function automatic t_req rand_req();
        t_req r;
        r.op = 2'($urandom_range(0, 3));
        r.w1 = rand_field(1'b1);
        r.n1 = rand_field(1'b1);
        r.d1 = rand_field(1'b1);
        r.w2 = rand_field(1'b1);
        r.n2 = rand_field(1'b1);
        r.d2 = rand_field(1'b1);
        if ($urandom_range(0, 3) == 0) r.w1 = -$signed(r.w1);
        if ($urandom_range(0, 3) == 0) r.w2 = -$signed(r.w2);
        if ($urandom_range(0, 24) == 0) begin
            r.w2 = '0;
            r.n2 = '0;
        end
        return r;
    endfunction

    // driver: next request goes out at the falling edge
    always @(negedge i_clk) begin
        t_req r;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || taken) begin
            taken <= 1'b0;
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid  <= 1'b0;
            end else if (pending_q.size() == 0
                         || (sent == DRAIN_AT && fraction_q.size() != 0)) begin
                i_valid <= 1'b0;
            end else begin
                r = pending_q.pop_front();
                i_operation    <= r.op;
                i_first_whole  <= r.w1;
                i_first_num    <= r.n1;
                i_first_den    <= r.d1;
                i_second_whole <= r.w2;
                i_second_num   <= r.n2;
                i_second_den   <= r.d2;
                i_valid  <= 1'b1;
                sent     <= sent + 1;
                send_gap <= pick_gap();
            end
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else begin
            stall_left <= pick_gap();
            i_stall    <= 1'b0;
        end
    end

    // request accepted: predict its result
    always @(posedge i_clk) begin
        t_req r;
        if (i_rst_n && i_valid && !o_stall) begin
            r = '{i_operation, i_first_whole, i_first_num, i_first_den,
                  i_second_whole, i_second_num, i_second_den};
            fraction_q.push_back(reduce_fraction(r));
            taken <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_frac e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (fraction_q.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected result whole=%0d num=%0d den=%0d zdiv=%0b",
                             o_result_whole, o_result_num, o_result_den, o_zero_divide);
            end else begin
                e = fraction_q.pop_front();
                if (o_result_whole !== e.whole || o_result_num !== e.num
                    || o_result_den !== e.den || o_zero_divide !== e.zdiv) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("result mismatch: exp %0d %0d/%0d z%0b, got %0d %0d/%0d z%0b",
                                 e.whole, e.num, e.den, e.zdiv, o_result_whole,
                                 o_result_num, o_result_den, o_zero_divide);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        t_req r;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_operation = OP_ADD;
        i_first_whole = '0;
        i_first_num = '0;
        i_first_den = OPERAND_BITS'(1);
        i_second_whole = '0;
        i_second_num = '0;
        i_second_den = OPERAND_BITS'(1);

        // extremes and special cases
        pending_q.push_back('{OP_ADD, 12'sd1, 12'd1, 12'd2, 12'sd2, 12'd1, 12'd3});
        pending_q.push_back('{OP_SUB, 12'sd3, 12'd1, 12'd4, 12'sd0, 12'd3, 12'd4});
        pending_q.push_back('{OP_MUL, -12'sd2, 12'd1, 12'd2, 12'sd3, 12'd2, 12'd5});
        pending_q.push_back('{OP_DIV, 12'sd5, 12'd0, 12'd1, -12'sd2, 12'd1, 12'd3});
        pending_q.push_back('{OP_ADD, 12'sd1, 12'd0, 12'd0, 12'sd1, 12'd0, 12'd1});
        pending_q.push_back('{OP_MUL, 12'sd1, 12'd0, 12'd1, 12'sd1, 12'd0, 12'd0});
        pending_q.push_back('{OP_DIV, 12'sd7, 12'd1, 12'd2, 12'sd0, 12'd0, 12'd9});
        pending_q.push_back('{OP_SUB, 12'sd2, 12'd1, 12'd3, 12'sd2, 12'd1, 12'd3});
        pending_q.push_back('{OP_ADD, -12'sd2048, 12'd4095, 12'd4095,
                              -12'sd2048, 12'd4095, 12'd4095});
        pending_q.push_back('{OP_MUL, -12'sd2048, 12'd4095, 12'd1,
                              -12'sd2048, 12'd4095, 12'd1});
        pending_q.push_back('{OP_MUL, 12'sd2047, 12'd4095, 12'd4095,
                              -12'sd2048, 12'd4095, 12'd4093});
        pending_q.push_back('{OP_DIV, 12'sd2047, 12'd4095, 12'd1,
                              12'sd0, 12'd1, 12'd4095});
        pending_q.push_back('{OP_DIV, 12'sd0, 12'd1, 12'd4095,
                              -12'sd2048, 12'd4095, 12'd1});
        pending_q.push_back('{OP_SUB, 12'sd0, 12'd0, 12'd4095, 12'sd0, 12'd0, 12'd1});
        pending_q.push_back('{OP_SUB, -12'sd2048, 12'd0, 12'd4094, 12'sd2047, 12'd0, 12'd4095});
        pending_q.push_back('{OP_ADD, 12'sd0, 12'd4095, 12'd7, 12'sd0, 12'd2730, 12'd2730});
        pending_q.push_back('{OP_DIV, 12'sd0, 12'd0, 12'd0, 12'sd0, 12'd0, 12'd0});
        while (pending_q.size() < 400) begin
            r = rand_req();
            pending_q.push_back(r);
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_q.size() != 0 || i_valid || fraction_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && fraction_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

FILE: files.f
rtl/mfa_pkg.sv
rtl/mfa_datapath.sv
rtl/mfa_control.sv
rtl/mixed_fraction_alu.sv
tb/sv/mixed_fraction_alu_tb.sv
